// ===== hdl/pem_pkg.sv =====
package pem_pkg;

    localparam int unsigned PAUSE_W = 20;
    localparam int unsigned REG_IDX_W = 2;

    localparam logic [PAUSE_W-1:0] PAUSE_MIN_RESET = PAUSE_W'(90000);
    localparam logic [PAUSE_W-1:0] PAUSE_MAX_RESET = PAUSE_W'(400000);
    localparam logic [PAUSE_W-1:0] DEADBAND_RESET = PAUSE_W'(2000);
    localparam logic [PAUSE_W-1:0] HELD_RESET = PAUSE_W'(90000);

    typedef logic [PAUSE_W-1:0] pause_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PAUSE_MIN = 2'd0,
        REG_PAUSE_MAX = 2'd1,
        REG_DEADBAND = 2'd2
    } reg_idx_t;

    typedef struct packed {
        pause_t pause_min;
        pause_t pause_max;
        pause_t deadband;
    } cfg_t;

endpackage

// ===== hdl/pem_sample_if.sv =====
interface pem_sample_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink (input valid, input raw_sample, output ready);
endinterface

// ===== hdl/pem_pause_if.sv =====
interface pem_pause_if;
    logic                         valid;
    logic                         ready;
    logic [pem_pkg::PAUSE_W-1:0]  pause_us;
    logic                         changed;

    modport source (output valid, output pause_us, output changed, input ready);
    modport sink (input valid, input pause_us, input changed, output ready);
endinterface

// ===== hdl/pem_ema.sv =====
module pem_ema #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    pem_sample_if.sink             sample,
    output logic                   avg_valid,
    output logic [SAMPLE_BITS-1:0] avg,
    input  logic                   avg_ready
);
    localparam int unsigned SUM_W = SAMPLE_BITS + 3;

    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [SAMPLE_BITS-1:0] avg_next;
    logic                   seeded_reg;
    logic                   s1_valid_reg;
    logic [SUM_W-1:0]       sum;
    logic                   accept;

    // 8*avg - avg + sample, then drop three bits
    assign sum = ({3'b000, avg_reg} << 3) - {3'b000, avg_reg} + {3'b000, sample.raw_sample};
    assign avg_next = seeded_reg ? sum[SUM_W-1:3] : sample.raw_sample;

    assign sample.ready = !s1_valid_reg || avg_ready;
    assign accept = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
            seeded_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
                s1_valid_reg <= sample.valid;
            if (accept)
            begin
                avg_reg <= avg_next;
                seeded_reg <= 1'b1;
            end
        end
    end

    assign avg_valid = s1_valid_reg;
    assign avg = avg_reg;
endmodule

// ===== hdl/pem_map.sv =====
module pem_map #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pem_pkg::cfg_t          cfg,
    input  logic                   avg_valid,
    input  logic [SAMPLE_BITS-1:0] avg,
    output logic                   avg_ready,
    output logic                   map_valid,
    output pem_pkg::pause_t        map_pause,
    input  logic                   map_ready
);
    localparam int unsigned PROD_W = SAMPLE_BITS + pem_pkg::PAUSE_W;
    localparam int unsigned FULL_INT = (1 << SAMPLE_BITS) - 1;
    localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'(FULL_INT);
    localparam int unsigned FOLDS = 4;

    logic                   s2_valid_reg;
    logic                   s3_valid_reg;
    logic                   s4_valid_reg;
    logic [PROD_W-1:0]      prod_reg;
    pem_pkg::pause_t        dec_reg;
    pem_pkg::pause_t        map_reg;
    logic                   en2;
    logic                   en3;
    logic                   en4;
    pem_pkg::pause_t        span;
    logic [PROD_W-1:0]      prod_next;
    pem_pkg::pause_t        dec_next;
    pem_pkg::pause_t        map_next;

    assign en4 = !s4_valid_reg || map_ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign avg_ready = en2;

    // span is zero once min passes max
    assign span = (cfg.pause_max >= cfg.pause_min) ? (cfg.pause_max - cfg.pause_min) : '0;
    assign prod_next = PROD_W'(avg) * PROD_W'(span);

    // divide by 2^SAMPLE_BITS - 1: fold the high digit onto the low one
    always_comb
    begin
        logic [PROD_W-1:0] q;
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] hi_part;
        q = '0;
        r = prod_reg;
        for (int i = 0; i < FOLDS; i++)
        begin
            hi_part = r >> SAMPLE_BITS;
            q = q + hi_part;
            r = hi_part + (r & FULL_SCALE);
        end
        if (r >= FULL_SCALE)
            q = q + PROD_W'(1);
        dec_next = q[pem_pkg::PAUSE_W-1:0];
    end

    always_comb
    begin
        pem_pkg::pause_t m;
        m = (dec_reg <= cfg.pause_max) ? (cfg.pause_max - dec_reg) : '0;
        if (m < cfg.pause_min)
            m = cfg.pause_min;
        if (m > cfg.pause_max)
            m = cfg.pause_max;
        map_next = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2)
                s2_valid_reg <= avg_valid;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && avg_valid)
            prod_reg <= prod_next;
        if (en3 && s2_valid_reg)
            dec_reg <= dec_next;
        if (en4 && s3_valid_reg)
            map_reg <= map_next;
    end

    assign map_valid = s4_valid_reg;
    assign map_pause = map_reg;
endmodule

// ===== hdl/pem_hold.sv =====
module pem_hold (
    input  logic            clk,
    input  logic            rst_n,
    input  pem_pkg::cfg_t   cfg,
    input  logic            map_valid,
    input  pem_pkg::pause_t map_pause,
    output logic            map_ready,
    pem_pause_if.source     pause
);
    localparam int unsigned CMP_W = pem_pkg::PAUSE_W + 1;

    pem_pkg::pause_t held_reg;
    logic            changed_reg;
    logic            out_valid_reg;
    logic            en_out;
    logic            move;
    logic [CMP_W-1:0] m_wide;
    logic [CMP_W-1:0] h_wide;
    logic [CMP_W-1:0] d_wide;

    assign m_wide = {1'b0, map_pause};
    assign h_wide = {1'b0, held_reg};
    assign d_wide = {1'b0, cfg.deadband};
    assign move = (m_wide > h_wide + d_wide) || (m_wide + d_wide < h_wide);

    assign en_out = !out_valid_reg || pause.ready;
    assign map_ready = en_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= pem_pkg::HELD_RESET;
            changed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= map_valid;
            if (map_valid)
            begin
                changed_reg <= move;
                if (move)
                    held_reg <= map_pause;
            end
        end
    end

    assign pause.valid = out_valid_reg;
    assign pause.pause_us = held_reg;
    assign pause.changed = changed_reg;
endmodule

// ===== hdl/pot_ema_pause_mapper.sv =====
// Potentiometer smoothing and pause mapping. Each sample item updates an
// exponential average (the first sample after reset loads it directly, later
// ones give floor((7*avg + sample)/8)), maps the average inversely onto a pause
// between pause_min and pause_max, and moves the held pause only when the new
// value is more than deadband away from it. Every sample gives exactly one
// result item: the held pause and a flag saying whether this sample moved it.
// One item is taken per clock while the downstream side does not stall. There
// are five register stages (average register, multiply, divide by full scale,
// clamp, deadband and hold); the edge that takes the sample loads the first,
// and the result leaves the last, where a downstream stall holds it. Bubbles
// in the pipeline are squeezed out, so samples are still taken while a finished
// result waits. Register writes land on the cycle wr_en is high and
// should only be made with no item in flight.
module pot_ema_pause_mapper #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [pem_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [pem_pkg::PAUSE_W-1:0]      wr_data,
    pem_sample_if.sink                       sample,
    pem_pause_if.source                      pause
);
    pem_pkg::cfg_t          cfg_reg;
    logic                   avg_valid;
    logic [SAMPLE_BITS-1:0] avg;
    logic                   avg_ready;
    logic                   map_valid;
    pem_pkg::pause_t        map_pause;
    logic                   map_ready;

    // Configuration registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pause_min <= pem_pkg::PAUSE_MIN_RESET;
            cfg_reg.pause_max <= pem_pkg::PAUSE_MAX_RESET;
            cfg_reg.deadband <= pem_pkg::DEADBAND_RESET;
        end
        else if (wr_en)
        begin
            unique case (pem_pkg::reg_idx_t'(wr_index))
                pem_pkg::REG_PAUSE_MIN: cfg_reg.pause_min <= wr_data;
                pem_pkg::REG_PAUSE_MAX: cfg_reg.pause_max <= wr_data;
                pem_pkg::REG_DEADBAND:  cfg_reg.deadband <= wr_data;
                default: ;
            endcase
        end
    end

    // Stage 1: take the sample, advance the running average
    pem_ema #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ema (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .avg_valid (avg_valid),
        .avg       (avg),
        .avg_ready (avg_ready)
    );

    // Stages 2 to 4: scale by span, divide by full scale, clamp to limits
    pem_map #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .avg_valid (avg_valid),
        .avg       (avg),
        .avg_ready (avg_ready),
        .map_valid (map_valid),
        .map_pause (map_pause),
        .map_ready (map_ready)
    );

    // Stage 5: deadband against the held pause, result register
    pem_hold u_hold (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .map_valid (map_valid),
        .map_pause (map_pause),
        .map_ready (map_ready),
        .pause     (pause)
    );
endmodule

// ===== hdl/pem_checker.sv =====
module pem_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pem_pkg::PAUSE_W-1:0] pause_us,
    input logic                        changed
);
    localparam logic [2:0] DEPTH = 3'd5;

    logic [2:0]      inflight_reg;
    pem_pkg::pause_t last_pause_reg;
    logic            in_acc;
    logic            out_acc;

    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            last_pause_reg <= pem_pkg::HELD_RESET;
        end
        else
        begin
            inflight_reg <= inflight_reg + 3'(in_acc) - 3'(out_acc);
            if (out_acc)
                last_pause_reg <= pause_us;
        end
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> inflight_reg != 3'd0)
        else $error("result delivered with no item in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= DEPTH)
        else $error("more items in flight than pipeline stages");

    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !changed |-> pause_us == last_pause_reg)
        else $error("pause moved without changed flag");

    a_hold_moved: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && changed |-> pause_us != last_pause_reg)
        else $error("changed flag set but pause unchanged");

    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pause_us) && $stable(changed))
        else $error("stalled result not held");
endmodule

bind pot_ema_pause_mapper pem_checker u_pem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (pause.valid),
    .out_ready (pause.ready),
    .pause_us  (pause.pause_us),
    .changed   (pause.changed)
);
